/* rtl/thermostat_setpoint_buttons_hysteresis_core_assert.svh */
// Assertion macros for the thermostat core checker.
// Every property is sampled on the rising edge of clk and is switched off while rst_n is low.
`ifndef THERMOSTAT_SETPOINT_BUTTONS_HYSTERESIS_CORE_ASSERT_SVH
`define THERMOSTAT_SETPOINT_BUTTONS_HYSTERESIS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSBH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsbh: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSBH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsbh: next-cycle check failed");

`endif

/* rtl/tsbh_pkg.sv */
package tsbh_pkg;

    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int HYST_W     = 5;
    localparam int SP_W       = 8;
    localparam int TEMP_W     = 12;
    localparam int FRAC_W     = 4;   // 1/16 degree resolution
    localparam int BAND_W     = 14;  // holds setpoint*16 +/- hysteresis*16
    localparam int NUM_BTN    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Button slots
    localparam int BTN_ADD    = 0;
    localparam int BTN_MINUS  = 1;
    localparam int BTN_SELECT = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_MS    = 3'd0,
        CFG_REPEAT_MS  = 3'd1,
        CFG_HYSTERESIS = 3'd2,
        CFG_SP_MIN     = 3'd3,
        CFG_SP_MAX     = 3'd4
    } cfg_index_t;

    localparam logic [MS_W-1:0]          HOLD_MS_RST   = 16'd50;
    localparam logic [MS_W-1:0]          REPEAT_MS_RST = 16'd100;
    localparam logic [HYST_W-1:0]        HYST_RST      = 5'd2;
    localparam logic signed [SP_W-1:0]   SP_MIN_RST    = -8'sd55;
    localparam logic signed [SP_W-1:0]   SP_MAX_RST    = 8'sd125;
    localparam logic signed [SP_W-1:0]   SP_RST        = 8'sd25;

    typedef struct packed {
        logic press;       // rising edge of the button level
        logic repeat_hit;  // held long enough and repeat interval elapsed
    } btn_event_t;

    function automatic btn_event_t btn_eval(
        input logic              down,
        input logic              was_down,
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] press_start,
        input logic [TIME_W-1:0] last_repeat,
        input logic [MS_W-1:0]   hold,
        input logic [MS_W-1:0]   rep
    );
        btn_event_t          ev;
        logic [TIME_W-1:0]   since_press;
        logic [TIME_W-1:0]   since_repeat;
        since_press     = now - press_start;
        since_repeat    = now - last_repeat;
        ev.press        = down && !was_down;
        ev.repeat_hit   = down && was_down
                          && (since_press  >= {{(TIME_W-MS_W){1'b0}}, hold})
                          && (since_repeat >= {{(TIME_W-MS_W){1'b0}}, rep});
        return ev;
    endfunction

endpackage

/* rtl/thermostat_setpoint_buttons_hysteresis_core.sv */
// Each accepted input word is held in the input register, then moves to the result register.
// Throughput: one word per cycle while the sink takes results; one input register and one result register
// with a single pass of compare and add logic between them.
// Reset (rst_n low, asynchronous): setpoint 25, regulating mode, relay off,
// button history cleared, registers back to hold 50 ms, repeat 100 ms,
// hysteresis 2, limits -55 and 125; both pipeline stages empty.
module thermostat_setpoint_buttons_hysteresis_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tick input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [tsbh_pkg::TIME_W-1:0]           now_ms,
    input  logic                                  add_pressed,
    input  logic                                  minus_pressed,
    input  logic                                  select_pressed,
    input  logic signed [tsbh_pkg::TEMP_W-1:0]    temperature,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  relay_on,
    output logic signed [tsbh_pkg::SP_W-1:0]      setpoint,
    output logic                                  thermostat_enabled,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tsbh_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tsbh_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tsbh_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MS_W-1:0]        hold_ms_reg;
    logic [MS_W-1:0]        repeat_ms_reg;
    logic [HYST_W-1:0]      hyst_reg;
    logic signed [SP_W-1:0] sp_min_reg;
    logic signed [SP_W-1:0] sp_max_reg;

    // The user must write only while the core is idle; the block does not enforce this and takes writes at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg   <= HOLD_MS_RST;
            repeat_ms_reg <= REPEAT_MS_RST;
            hyst_reg      <= HYST_RST;
            sp_min_reg    <= SP_MIN_RST;
            sp_max_reg    <= SP_MAX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_HOLD_MS:    hold_ms_reg   <= cfg_data;
                CFG_REPEAT_MS:  repeat_ms_reg <= cfg_data;
                CFG_HYSTERESIS: hyst_reg      <= cfg_data[HYST_W-1:0];
                CFG_SP_MIN:     sp_min_reg    <= cfg_data[SP_W-1:0];
                CFG_SP_MAX:     sp_max_reg    <= cfg_data[SP_W-1:0];
                default:        ;  // indexes past the list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic                     in_valid_reg;
    logic                     in_valid_next;
    logic [TIME_W-1:0]        now_reg;
    logic [NUM_BTN-1:0]       btn_down_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    logic                     out_valid_reg;
    logic                     advance;

    // Move the held word into the result register whenever that register
    // is empty or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    // Accept a new word while the held one leaves, so ticks can stream.
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload of the input stage: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg                  <= now_ms;
            btn_down_reg[BTN_ADD]    <= add_pressed;
            btn_down_reg[BTN_MINUS]  <= minus_pressed;
            btn_down_reg[BTN_SELECT] <= select_pressed;
            temp_reg                 <= temperature;
        end
    end

    // ------------------------------------------------------------------
    // Thermostat state
    // ------------------------------------------------------------------
    logic signed [SP_W-1:0] setpoint_reg;
    logic signed [SP_W-1:0] setpoint_next;
    logic                   mode_reg;
    logic                   mode_next;
    logic                   relay_reg;
    logic                   relay_next;
    logic [NUM_BTN-1:0]     was_down_reg;
    logic [TIME_W-1:0]      press_start_reg [NUM_BTN];
    logic [TIME_W-1:0]      last_repeat_reg [NUM_BTN];

    btn_event_t             btn_ev [NUM_BTN];

    // Evaluate all three buttons side by side against their own history.
    always_comb
    begin
        for (int b = 0; b < NUM_BTN; b++)
        begin
            btn_ev[b] = btn_eval(btn_down_reg[b], was_down_reg[b], now_reg,
                                 press_start_reg[b], last_repeat_reg[b],
                                 hold_ms_reg, repeat_ms_reg);
        end
    end

    logic                     act_add;
    logic                     act_minus;
    logic                     act_select;
    logic signed [SP_W-1:0]   sp_after_add;
    logic signed [BAND_W-1:0] sp16;
    logic signed [BAND_W-1:0] band16;
    logic signed [BAND_W-1:0] band_hi;
    logic signed [BAND_W-1:0] band_lo;
    logic signed [BAND_W-1:0] temp_ext;

    // Add and minus step on the press edge and on repeat; select only on
    // repeat, so a short press of select does nothing.
    assign act_add    = btn_ev[BTN_ADD].press   || btn_ev[BTN_ADD].repeat_hit;
    assign act_minus  = btn_ev[BTN_MINUS].press || btn_ev[BTN_MINUS].repeat_hit;
    assign act_select = btn_ev[BTN_SELECT].repeat_hit;

    always_comb
    begin
        // Add first, then minus; each saturates at its own limit.
        sp_after_add = setpoint_reg;
        if (act_add)
        begin
            sp_after_add = (setpoint_reg >= sp_max_reg) ? sp_max_reg
                                                        : setpoint_reg + 8'sd1;
        end
        setpoint_next = sp_after_add;
        if (act_minus)
        begin
            setpoint_next = (sp_after_add <= sp_min_reg) ? sp_min_reg
                                                         : sp_after_add - 8'sd1;
        end
    end

    // Bring setpoint and band to 1/16 degree so they line up with the sensor.
    assign sp16     = {{(BAND_W-SP_W-FRAC_W){setpoint_next[SP_W-1]}}, setpoint_next,
                       {FRAC_W{1'b0}}};
    assign band16   = {{(BAND_W-HYST_W-FRAC_W){1'b0}}, hyst_reg, {FRAC_W{1'b0}}};
    assign band_hi  = sp16 + band16;
    assign band_lo  = sp16 - band16;
    assign temp_ext = {{(BAND_W-TEMP_W){temp_reg[TEMP_W-1]}}, temp_reg};

    always_comb
    begin
        // The relay sees the mode from before this tick's toggle.
        relay_next = relay_reg;
        if (!mode_reg)
        begin
            relay_next = 1'b0;
        end
        else if (temp_ext > band_hi)
        begin
            relay_next = 1'b0;
        end
        else if (temp_ext < band_lo)
        begin
            relay_next = 1'b1;
        end
        mode_next = act_select ? !mode_reg : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= SP_RST;
            mode_reg     <= 1'b1;
            relay_reg    <= 1'b0;
            was_down_reg <= '0;
            for (int b = 0; b < NUM_BTN; b++)
            begin
                press_start_reg[b] <= '0;
                last_repeat_reg[b] <= '0;
            end
        end
        else if (advance)
        begin
            setpoint_reg <= setpoint_next;
            mode_reg     <= mode_next;
            relay_reg    <= relay_next;
            was_down_reg <= btn_down_reg;
            for (int b = 0; b < NUM_BTN; b++)
            begin
                // A fresh press restarts both timers; a repeat restarts
                // only the repeat timer.
                if (btn_ev[b].press)
                begin
                    press_start_reg[b] <= now_reg;
                    last_repeat_reg[b] <= now_reg;
                end
                else if (btn_ev[b].repeat_hit)
                begin
                    last_repeat_reg[b] <= now_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register stage
    // ------------------------------------------------------------------
    logic                   out_valid_next;
    logic                   out_relay_reg;
    logic signed [SP_W-1:0] out_sp_reg;
    logic                   out_mode_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result word until the sink takes it.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_relay_reg <= relay_next;
            out_sp_reg    <= setpoint_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign relay_on           = out_relay_reg;
    assign setpoint           = out_sp_reg;
    assign thermostat_enabled = out_mode_reg;

endmodule

/* rtl/tsbh_checker.sv */
`include "thermostat_setpoint_buttons_hysteresis_core_assert.svh"

module tsbh_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               relay_on,
    input logic signed [tsbh_pkg::SP_W-1:0]   setpoint,
    input logic                               thermostat_enabled,
    input logic                               cfg_valid,
    input logic                               cfg_ready
);

    // A stalled result word stays offered.
    `TSBH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // A stalled result word keeps its contents.
    `TSBH_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(setpoint) && $stable(relay_on) && $stable(thermostat_enabled))

    // Input back-pressure only ever comes from a stalled result word.
    `TSBH_ASSERT_NOW(a_in_stall_cause, !in_ready, out_valid && !out_ready)

    // Configuration writes are never held off.
    `TSBH_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind thermostat_setpoint_buttons_hysteresis_core tsbh_checker u_tsbh_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .relay_on           (relay_on),
    .setpoint           (setpoint),
    .thermostat_enabled (thermostat_enabled),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready)
);

/* tb/thermostat_setpoint_buttons_hysteresis_core_tb.sv */
`timescale 1ns / 1ps

module thermostat_setpoint_buttons_hysteresis_core_tb;

    import tsbh_pkg::*;

    // One expected result word: relay drive, setpoint and mode after the tick.
    typedef struct packed {
        logic       relay;
        logic [7:0] sp;
        logic       en;
    } reading_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [TIME_W-1:0]         now_ms;
    logic                      add_pressed;
    logic                      minus_pressed;
    logic                      select_pressed;
    logic signed [TEMP_W-1:0]  temperature;
    logic                      out_valid;
    logic                      out_ready;
    logic                      relay_on;
    logic signed [SP_W-1:0]    setpoint;
    logic                      thermostat_enabled;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // Predicted register file of the block.
    logic [15:0]               hold_cfg;
    logic [15:0]               repeat_cfg;
    logic [4:0]                hyst_cfg;
    logic signed [7:0]         min_cfg;
    logic signed [7:0]         max_cfg;

    // Predicted thermostat state; button slots follow the package order.
    logic signed [7:0]         model_setpoint;
    logic                      model_enabled;
    logic                      model_relay;
    logic                      btn_held      [NUM_BTN];
    logic [31:0]               btn_pressed_at[NUM_BTN];
    logic [31:0]               btn_fired_at  [NUM_BTN];

    reading_t                  pending_readings[$];
    int                        failures;

    // Stimulus bookkeeping: running clock of the ticks and the button levels.
    logic [31:0]               tick_clock;
    logic [2:0]                held_levels;
    bit                        tx_idle_en;
    bit                        rx_idle_en;
    int                        holdoff_asked;
    int                        holdoff_seen;
    int                        holdoff_left;

    thermostat_setpoint_buttons_hysteresis_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .now_ms             (now_ms),
        .add_pressed        (add_pressed),
        .minus_pressed      (minus_pressed),
        .select_pressed     (select_pressed),
        .temperature        (temperature),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .relay_on           (relay_on),
        .setpoint           (setpoint),
        .thermostat_enabled (thermostat_enabled),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Advance one button slot by a tick; report whether it acts. Elapsed times
    // are plain 32-bit differences, so the millisecond clock may wrap freely.
    function automatic logic button_fires(input int b, input logic down,
                                          input logic [31:0] now, input logic on_edge);
        logic        act;
        logic [31:0] since_press;
        logic [31:0] since_fire;
        act         = 1'b0;
        since_press = now - btn_pressed_at[b];
        since_fire  = now - btn_fired_at[b];
        if (down && !btn_held[b])
        begin
            btn_pressed_at[b] = now;
            btn_fired_at[b]   = now;
            act               = on_edge;
        end
        else if (down && since_press >= {16'd0, hold_cfg} && since_fire >= {16'd0, repeat_cfg})
        begin
            btn_fired_at[b] = now;
            act             = 1'b1;
        end
        btn_held[b] = down;
        return act;
    endfunction

    // Work out the result word of one accepted tick and queue it.
    task automatic advance_thermostat(input logic [31:0] now, input logic add,
                                      input logic minus, input logic sel,
                                      input logic signed [11:0] temp);
        int       sp16;
        int       band;
        reading_t r;
        // Add first, then minus; saturation compares against the limits as written,
        // even when they are crossed or the setpoint lies outside them.
        if (button_fires(BTN_ADD, add, now, 1'b1))
            model_setpoint = (model_setpoint >= max_cfg) ? max_cfg : model_setpoint + 8'sd1;
        if (button_fires(BTN_MINUS, minus, now, 1'b1))
            model_setpoint = (model_setpoint <= min_cfg) ? min_cfg : model_setpoint - 8'sd1;
        // Relay sees the new setpoint but the mode from before this tick's toggle.
        if (model_enabled)
        begin
            sp16 = int'(model_setpoint) * 16;
            band = int'(hyst_cfg) * 16;
            if (int'(temp) > sp16 + band)
                model_relay = 1'b0;
            else if (int'(temp) < sp16 - band)
                model_relay = 1'b1;
        end
        else
            model_relay = 1'b0;
        // Select never acts on the press edge, only on repeat.
        if (button_fires(BTN_SELECT, sel, now, 1'b0))
            model_enabled = !model_enabled;
        r.relay = model_relay;
        r.sp    = model_setpoint;
        r.en    = model_enabled;
        pending_readings.push_back(r);
    endtask

    // Offer one tick word, idling beforehand at random when tx_idle_en is set, and hold it until taken.
    task automatic send_tick(input logic [31:0] now, input logic add, input logic minus,
                             input logic sel, input logic signed [11:0] temp);
        if (tx_idle_en)
            while ($urandom_range(99) < 29)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid       <= 1'b1;
        now_ms         <= now;
        add_pressed    <= add;
        minus_pressed  <= minus;
        select_pressed <= sel;
        temperature    <= temp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_thermostat(now, add, minus, sel, temp);
    endtask

    // Stop offering and wait for every queued result word, then let the pipe settle.
    task automatic wait_for_readings();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HOLD_MS:    hold_cfg   = data;
            CFG_REPEAT_MS:  repeat_cfg = data;
            CFG_HYSTERESIS: hyst_cfg   = data[4:0];
            CFG_SP_MIN:     min_cfg    = data[7:0];
            CFG_SP_MAX:     max_cfg    = data[7:0];
            default: ;
        endcase
        // Drop valid for a cycle so back-to-back writes never clash in one step.
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram every register with the block idle.
    task automatic apply_settings(input logic [15:0] hold, input logic [15:0] rep,
                                  input logic [4:0] hyst, input logic signed [7:0] lo,
                                  input logic signed [7:0] hi);
        wait_for_readings();
        write_reg(CFG_HOLD_MS, hold);
        write_reg(CFG_REPEAT_MS, rep);
        write_reg(CFG_HYSTERESIS, {11'd0, hyst});
        write_reg(CFG_SP_MIN, {{8{lo[7]}}, lo});
        write_reg(CFG_SP_MAX, {{8{hi[7]}}, hi});
    endtask

    // Mostly well-formed button traffic on an advancing clock: levels change now
    // and then so presses last long enough to repeat. A few ticks jump the clock
    // anywhere or scramble all three levels at once.
    task automatic run_random_ticks(input int count, input int unsigned max_step);
        int                 i;
        int                 b;
        int                 r;
        int                 t;
        int                 spread;
        logic signed [11:0] temp;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                tick_clock = $urandom();
            else
                tick_clock = tick_clock + $urandom_range(max_step);
            if (r >= 96)
                held_levels = 3'($urandom_range(7));
            else
                for (b = 0; b < NUM_BTN; b++)
                    if ($urandom_range(99) < 12)
                        held_levels[b] = ~held_levels[b];
            // Keep most temperatures around the dead band so the relay both holds
            // and switches; the rest span -880 to 2000, that is -55 to 125 degrees.
            if ($urandom_range(99) < 20)
                t = int'($urandom_range(2880)) - 880;
            else
            begin
                spread = int'(hyst_cfg) * 16 + 48;
                t = int'(model_setpoint) * 16 + int'($urandom_range(2 * spread)) - spread;
            end
            if (t < -880)
                t = -880;
            if (t > 2000)
                t = 2000;
            temp = t[11:0];
            send_tick(tick_clock, held_levels[0], held_levels[1], held_levels[2], temp);
        end
    endtask

    // Temperature extremes and both edges of the dead band at reset settings.
    task automatic test_relay_band();
        send_tick(32'd0, 1'b0, 1'b0, 1'b0, 12'sd2000);
        send_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, -12'sd880);
        send_tick(32'd2, 1'b0, 1'b0, 1'b0, 12'sd432);
        send_tick(32'd3, 1'b0, 1'b0, 1'b0, 12'sd433);
        send_tick(32'd4, 1'b0, 1'b0, 1'b0, 12'sd368);
        send_tick(32'd5, 1'b0, 1'b0, 1'b0, 12'sd367);
    endtask

    // Press edge, hold inside and past the hold time, repeat spacing, release,
    // and both step buttons pressed on the same tick.
    task automatic test_button_timing();
        send_tick(32'd10,  1'b1, 1'b0, 1'b0, 12'sd400);
        send_tick(32'd40,  1'b1, 1'b0, 1'b0, 12'sd400);
        send_tick(32'd110, 1'b1, 1'b0, 1'b0, 12'sd400);
        send_tick(32'd150, 1'b1, 1'b0, 1'b0, 12'sd400);
        send_tick(32'd160, 1'b0, 1'b0, 1'b0, 12'sd400);
        send_tick(32'd170, 1'b0, 1'b1, 1'b0, 12'sd400);
        send_tick(32'd180, 1'b0, 1'b0, 1'b0, 12'sd400);
        send_tick(32'd190, 1'b1, 1'b1, 1'b0, 12'sd400);
        send_tick(32'd200, 1'b0, 1'b0, 1'b0, 12'sd400);
    endtask

    // Select held across a clock wrap: no toggle on the edge, and the toggling
    // tick still drives the relay with the old mode. Steps work while disabled.
    task automatic test_mode_toggle();
        send_tick(32'hFFFF_FFC0, 1'b0, 1'b0, 1'b1, 12'sd2000);
        send_tick(32'h0000_0040, 1'b0, 1'b0, 1'b1, -12'sd880);
        send_tick(32'h0000_0050, 1'b0, 1'b0, 1'b0, -12'sd880);
        send_tick(32'h0000_0060, 1'b1, 1'b0, 1'b0, -12'sd880);
        send_tick(32'h0000_0100, 1'b0, 1'b0, 1'b1, -12'sd880);
        send_tick(32'h0000_0200, 1'b0, 1'b0, 1'b1, -12'sd880);
        send_tick(32'h0000_0210, 1'b0, 1'b0, 1'b0, -12'sd880);
    endtask

    // Setpoint left outside new limits until a step clamps it, then crossed limits.
    task automatic test_limits();
        apply_settings(16'd50, 16'd100, 5'd2, 8'sd30, 8'sd40);
        send_tick(32'h0000_0300, 1'b0, 1'b0, 1'b0, 12'sd432);
        send_tick(32'h0000_0310, 1'b0, 1'b1, 1'b0, 12'sd432);
        apply_settings(16'd50, 16'd100, 5'd2, 8'sd125, -8'sd55);
        send_tick(32'h0000_0400, 1'b1, 1'b0, 1'b0, 12'sd432);
        send_tick(32'h0000_0410, 1'b1, 1'b1, 1'b0, 12'sd432);
        tick_clock  = 32'h0000_0500;
        held_levels = 3'b011;
    endtask

    // Random traffic under a spread of settings, register extremes among them.
    task automatic test_register_sweep();
        apply_settings(16'd50, 16'd100, 5'd2, -8'sd55, 8'sd125);
        run_random_ticks(90, 40);
        apply_settings(16'd0, 16'd0, 5'd0, 8'sd20, 8'sd30);
        run_random_ticks(90, 5);
        apply_settings(16'd65535, 16'd65535, 5'd31, -8'sd55, 8'sd125);
        run_random_ticks(90, 30000);
        apply_settings(16'd10, 16'd30, 5'd1, 8'sd125, -8'sd55);
        run_random_ticks(90, 20);
        apply_settings(16'd200, 16'd20, 5'd5, -8'sd55, -8'sd40);
        run_random_ticks(90, 60);
        apply_settings(16'd7, 16'd300, 5'd12, -8'sd20, 8'sd60);
        run_random_ticks(90, 80);
    endtask

    // Receiver holds off for a long stretch while ticks keep coming, so the
    // block fills and stalls its input; then pause until all words are back.
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        holdoff_asked++;
        run_random_ticks(30, 40);
        wait_for_readings();
        tx_idle_en = 1'b1;
    endtask

    // Full rate on both sides with no idling at all.
    task automatic test_streaming();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_ticks(100, 40);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Result side: check each accepted word against the oldest expectation,
    // then choose out_ready for the next cycle.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("result word with no expectation waiting");
                failures++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (relay_on !== want.relay)
                begin
                    $error("relay_on: expected %0b, actual %0b", want.relay, relay_on);
                    failures++;
                end
                if (setpoint !== want.sp)
                begin
                    $error("setpoint: expected %0d, actual %0d",
                           $signed(want.sp), setpoint);
                    failures++;
                end
                if (thermostat_enabled !== want.en)
                begin
                    $error("thermostat_enabled: expected %0b, actual %0b",
                           want.en, thermostat_enabled);
                    failures++;
                end
            end
        end
        // Load a fresh hold-off when one is asked for, and count it down here.
        if (holdoff_seen != holdoff_asked)
        begin
            holdoff_seen = holdoff_asked;
            holdoff_left = 250;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else if (rx_idle_en)
            out_ready <= ($urandom_range(99) >= 29);
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        int i;
        // Drive every input to a known value and hold reset from the start.
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        now_ms         <= '0;
        add_pressed    <= 1'b0;
        minus_pressed  <= 1'b0;
        select_pressed <= 1'b0;
        temperature    <= '0;
        out_ready      <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= CFG_HOLD_MS;
        cfg_data       <= '0;
        failures       = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        holdoff_asked  = 0;
        holdoff_seen   = 0;
        holdoff_left   = 0;
        tick_clock     = '0;
        held_levels    = '0;
        // Predictor starts from the reset state of the block.
        hold_cfg       = 16'd50;
        repeat_cfg     = 16'd100;
        hyst_cfg       = 5'd2;
        min_cfg        = -8'sd55;
        max_cfg        = 8'sd125;
        model_setpoint = 8'sd25;
        model_enabled  = 1'b1;
        model_relay    = 1'b0;
        for (i = 0; i < NUM_BTN; i++)
        begin
            btn_held[i]       = 1'b0;
            btn_pressed_at[i] = '0;
            btn_fired_at[i]   = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_relay_band();
        test_button_timing();
        test_mode_toggle();
        test_limits();
        test_register_sweep();
        test_backpressure();
        test_streaming();

        // Drain with a bound, then let the pipe settle.
        in_valid <= 1'b0;
        for (i = 0; i < 5000 && pending_readings.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("%0d result words never arrived", pending_readings.size());
            failures++;
        end
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/tsbh_pkg.sv
rtl/thermostat_setpoint_buttons_hysteresis_core.sv
rtl/tsbh_checker.sv
tb/thermostat_setpoint_buttons_hysteresis_core_tb.sv
